### rtl/sym_pkg.sv
`default_nettype none
package sym_pkg;
	localparam int MAX_ENTRIES = 1024;
	localparam int MAX_OPS = 64;
	localparam int FRAC_BITS = 24;
	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam int SLOT_W = $clog2(MAX_OPS);
	localparam int OPI_W = $clog2(MAX_OPS * 3);
	localparam int COORD_W = FRAC_BITS + 1;
	localparam int QD = 4;
	localparam int QA_W = 2;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_APPLY = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_DUP   = 3'd1,
		ST_FULL  = 3'd2,
		ST_ACK   = 3'd3,
		ST_BAD   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_SUM,
		F_PUSH
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic                 scan;
		status_t              status;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   z;
		logic [7:0]           kind;
		logic                 clear;
	} job_t;

	function automatic logic [COORD_W-1:0] fold(input logic signed [31:0] v,
			input logic [24:0] tol);
		logic signed [33:0] one;
		logic signed [33:0] vv;
		logic signed [33:0] t;
		logic signed [33:0] nv;
		one = 34'sd1 <<< FRAC_BITS;
		vv = 34'(v);
		t = 34'(signed'({9'd0, tol}));
		nv = -vv;
		if (vv > one) fold = COORD_W'(vv[FRAC_BITS-1:0]);
		else if (vv < t && vv > -t) fold = '0;
		else if (vv < 0) fold = COORD_W'(one - 34'(nv[FRAC_BITS-1:0]));
		else if (vv > one - t) fold = COORD_W'(one);
		else fold = COORD_W'(vv);
	endfunction

	function automatic logic near(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b, input logic [24:0] tol);
		logic signed [COORD_W+1:0] d;
		logic signed [COORD_W+1:0] t;
		d = signed'({2'b0, a}) - signed'({2'b0, b});
		t = signed'((COORD_W + 2)'(tol));
		near = (d <= t) && (d >= -t);
	endfunction
endpackage
`default_nettype wire

### rtl/sym_front.sv
`default_nettype none
module sym_front (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire [1:0]                 op,
	input  wire [5:0]                 op_slot,
	input  wire [1:0]                 row,
	input  wire signed [2:0]          rot_a,
	input  wire signed [2:0]          rot_b,
	input  wire signed [2:0]          rot_c,
	input  wire signed [31:0]         shift,
	input  wire signed [31:0]         pos_x,
	input  wire signed [31:0]         pos_y,
	input  wire signed [31:0]         pos_z,
	input  wire [7:0]                 atom_type,
	input  wire [24:0]                snap_tol,
	input  wire [6:0]                 op_count,
	input  wire                       q_full,
	output logic                      q_push,
	output sym_pkg::job_t             q_job
);
	import sym_pkg::*;

	logic [8:0]  rot_mem [MAX_OPS*3];
	logic [31:0] tr_mem [MAX_OPS*3];
	fr_state_t   st_q, st_d;
	logic [1:0]  r_q;
	logic [OPI_W-1:0] base_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [7:0]  kind_q;
	logic [8:0]  rrot_q;
	logic [31:0] rtr_q;
	logic signed [35:0] m0_q, m1_q, m2_q;
	logic [COORD_W-1:0] c_q [3];
	logic signed [36:0] sum;
	logic signed [31:0] sat;
	logic [OPI_W-1:0] ra;
	logic [6:0]  lim;

	assign busy = (st_q != F_IDLE) || q_full;
	assign lim = (op_count > 7'(MAX_OPS)) ? 7'(MAX_OPS) : op_count;
	// row 0 is fetched at acceptance, the next row while the current one is summed
	assign ra = (st_q == F_IDLE) ? OPI_W'(op_slot) * OPI_W'(3)
		: (r_q >= 2'd2) ? base_q : base_q + OPI_W'(r_q) + OPI_W'(1);

	always_ff @(posedge clk) begin
		if (start && !busy && op == OP_LOAD && row != 2'd3 && 7'(op_slot) < 7'(MAX_OPS)) begin
			rot_mem[OPI_W'(op_slot) * OPI_W'(3) + OPI_W'(row)] <= {rot_a, rot_b, rot_c};
			tr_mem[OPI_W'(op_slot) * OPI_W'(3) + OPI_W'(row)] <= shift;
		end
		rrot_q <= rot_mem[ra];
		rtr_q <= tr_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			r_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == F_IDLE) r_q <= '0;
			else if (st_q == F_SUM) r_q <= r_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			base_q <= OPI_W'(op_slot) * OPI_W'(3);
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
			kind_q <= atom_type;
		end
		m0_q <= 36'(signed'(rrot_q[8:6])) * 36'(px_q);
		m1_q <= 36'(signed'(rrot_q[5:3])) * 36'(py_q);
		m2_q <= 36'(signed'(rrot_q[2:0])) * 36'(pz_q) + 36'(signed'(rtr_q));
		if (st_q == F_SUM) c_q[r_q] <= fold(sat, snap_tol);
	end

	always_comb begin
		sum = 37'(m0_q) + 37'(m1_q) + 37'(m2_q);
		if (sum > 37'sd2147483647) sat = 32'sh7fffffff;
		else if (sum < -37'sd2147483648) sat = 32'sh80000000;
		else sat = 32'(sum);
	end

	// item classification and transform sequencing
	always_comb begin
		st_d = st_q;
		q_push = 1'b0;
		q_job = '0;
		q_job.status = ST_ACK;
		case (st_q)
			F_IDLE: begin
				if (start && !q_full) begin
					q_push = 1'b1;
					case (op)
						OP_CLEAR: q_job.clear = 1'b1;
						OP_LOAD: if (row == 2'd3 || 7'(op_slot) >= 7'(MAX_OPS))
							q_job.status = ST_BAD;
						OP_APPLY: begin
							if (7'(op_slot) >= lim) q_job.status = ST_BAD;
							else begin
								q_push = 1'b0;
								st_d = F_MUL;
							end
						end
						default: ;
					endcase
				end
			end
			F_MUL: st_d = F_SUM;
			F_SUM: st_d = (r_q == 2'd2) ? F_PUSH : F_MUL;
			F_PUSH: begin
				if (!q_full) begin
					q_push = 1'b1;
					q_job.scan = 1'b1;
					q_job.x = c_q[0];
					q_job.y = c_q[1];
					q_job.z = c_q[2];
					q_job.kind = kind_q;
					st_d = F_IDLE;
				end
			end
			default: st_d = F_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/sym_queue.sv
`default_nettype none
module sym_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  sym_pkg::job_t  din,
	output logic           full,
	input  wire            pop,
	output logic           not_empty,
	output sym_pkg::job_t  dout
);
	import sym_pkg::*;

	job_t          mem_q [QD];
	logic [QA_W-1:0] wp_q, rp_q;
	logic [QA_W:0]   cnt_q;

	assign full = (cnt_q == (QA_W+1)'(QD));
	assign not_empty = (cnt_q != '0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (pop && not_empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QA_W+1)'(push && !full) - (QA_W+1)'(pop && not_empty);
		end
	end
endmodule
`default_nettype wire

### rtl/sym_back.sv
`default_nettype none
module sym_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       q_valid,
	input  sym_pkg::job_t             q_job,
	output logic                      q_pop,
	input  wire [24:0]                dup_tol,
	output logic                      idle,
	output logic                      done,
	output logic [2:0]                status,
	output logic [24:0]               out_x,
	output logic [24:0]               out_y,
	output logic [24:0]               out_z,
	output logic [7:0]                out_type,
	output logic [9:0]                entry_index
);
	import sym_pkg::*;

	logic [3*COORD_W-1:0] ent_mem [MAX_ENTRIES];
	logic [3*COORD_W-1:0] rd_q;
	bk_state_t st_q, st_d;
	job_t      job_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_d;
	logic             hit;
	logic             wr;
	status_t          res_st_q;
	logic [IDX_W-1:0] res_idx_q;
	logic             set_res;
	status_t          res_st_d;
	logic [IDX_W-1:0] res_idx_d;

	assign idle = (st_q == BK_IDLE) && !q_valid;
	assign hit = near(rd_q[3*COORD_W-1:2*COORD_W], job_q.x, dup_tol)
		&& near(rd_q[2*COORD_W-1:COORD_W], job_q.y, dup_tol)
		&& near(rd_q[COORD_W-1:0], job_q.z, dup_tol);

	always_ff @(posedge clk) begin
		if (wr) ent_mem[cnt_q[IDX_W-1:0]] <= {job_q.x, job_q.y, job_q.z};
		rd_q <= ent_mem[k_d[IDX_W-1:0]];
		if (q_pop) job_q <= q_job;
		if (set_res) begin
			res_st_q <= res_st_d;
			res_idx_q <= res_idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			cnt_q <= '0;
			k_q <= '0;
		end else begin
			st_q <= st_d;
			k_q <= k_d;
			if (q_pop && q_job.clear) cnt_q <= '0;
			else if (wr) cnt_q <= cnt_q + 1'b1;
		end
	end

	// scan: rd_q holds entry k_q in BK_SCAN
	always_comb begin
		st_d = st_q;
		k_d = k_q;
		q_pop = 1'b0;
		wr = 1'b0;
		set_res = 1'b0;
		res_st_d = job_q.status;
		res_idx_d = '0;
		case (st_q)
			BK_IDLE: begin
				k_d = '0;
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_job.scan) st_d = BK_SCAN;
					else st_d = BK_DONE;
				end
			end
			BK_SCAN: begin
				k_d = k_q + 1'b1;
				if (k_q == cnt_q) begin
					set_res = 1'b1;
					st_d = BK_DONE;
					if (cnt_q == CNT_W'(MAX_ENTRIES)) res_st_d = ST_FULL;
					else begin
						res_st_d = ST_ADDED;
						res_idx_d = cnt_q[IDX_W-1:0];
						wr = 1'b1;
					end
				end else if (hit) begin
					set_res = 1'b1;
					res_st_d = ST_DUP;
					res_idx_d = k_q[IDX_W-1:0];
					st_d = BK_DONE;
				end
			end
			BK_DONE: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		done = (st_q == BK_DONE);
		status = job_q.scan ? res_st_q : job_q.status;
		out_x = job_q.scan ? job_q.x : '0;
		out_y = job_q.scan ? job_q.y : '0;
		out_z = job_q.scan ? job_q.z : '0;
		out_type = job_q.scan ? job_q.kind : '0;
		entry_index = job_q.scan ? 10'(res_idx_q) : '0;
	end
endmodule
`default_nettype wire

### rtl/symmetry_apply_fold_dedup_core.sv
`default_nettype none
// Symmetry apply, fold and duplicate removal.
// Item channel: start with the item fields is taken when busy is low. op selects
// clear list, load one operation row, apply an operation to an atom, or nothing.
// Result channel: done pulses one cycle with status, out_x/y/z, out_type and
// entry_index; results come out in item order and must be taken that cycle.
// A front unit classifies items and runs the transform (F_MUL, F_SUM per row, then
// F_PUSH; busy until the atom is pushed, taking no new item meanwhile); a 4-deep
// queue feeds the back unit. busy also stays high while the queue is full.
// Clear, load and rejected items skip the scan: the back unit pops them from the
// queue and goes straight to BK_DONE.
// An atom is compared against the stored list one entry per cycle from the
// single read port of the list memory, stopping at the first hit; the list
// holds up to 1024 entries.
// Configuration over APB: dup_tol at 0x0, snap_tol at 0x4, op_count at 0x8;
// write only while the block is idle.
// Reset clears the list count, the queue and the registers to their defaults;
// the list and the operation table keep undefined contents until written.
module symmetry_apply_fold_dedup_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [3:0]          paddr,
	input  wire [31:0]         pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire                start,
	output logic               busy,
	input  wire [1:0]          op,
	input  wire [5:0]          op_slot,
	input  wire [1:0]          row,
	input  wire signed [2:0]   rot_a,
	input  wire signed [2:0]   rot_b,
	input  wire signed [2:0]   rot_c,
	input  wire signed [31:0]  shift,
	input  wire signed [31:0]  pos_x,
	input  wire signed [31:0]  pos_y,
	input  wire signed [31:0]  pos_z,
	input  wire [7:0]          atom_type,
	output logic               done,
	output logic [2:0]         status,
	output logic [24:0]        out_x,
	output logic [24:0]        out_y,
	output logic [24:0]        out_z,
	output logic [7:0]         out_type,
	output logic [9:0]         entry_index
);
	import sym_pkg::*;

	logic [24:0] dup_tol_q, snap_tol_q;
	logic [6:0]  op_count_q;
	logic        q_full, q_push, q_pop, q_valid, bk_idle;
	job_t        f_job, b_job;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_tol_q <= 25'd16777;
			snap_tol_q <= 25'd168;
			op_count_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				4'h0: dup_tol_q <= pwdata[24:0];
				4'h4: snap_tol_q <= pwdata[24:0];
				4'h8: op_count_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			4'h0: prdata = {7'd0, dup_tol_q};
			4'h4: prdata = {7'd0, snap_tol_q};
			4'h8: prdata = {25'd0, op_count_q};
			default: prdata = '0;
		endcase
	end

	sym_front u_front (
		.clk, .arst_n, .start, .busy, .op, .op_slot, .row, .rot_a, .rot_b, .rot_c,
		.shift, .pos_x, .pos_y, .pos_z, .atom_type,
		.snap_tol(snap_tol_q), .op_count(op_count_q),
		.q_full, .q_push, .q_job(f_job)
	);

	sym_queue u_queue (
		.clk, .arst_n, .push(q_push), .din(f_job), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .dout(b_job)
	);

	sym_back u_back (
		.clk, .arst_n, .q_valid, .q_job(b_job), .q_pop, .dup_tol(dup_tol_q),
		.idle(bk_idle), .done, .status, .out_x, .out_y, .out_z, .out_type,
		.entry_index
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue overflow");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= 3'd4)) else $error("bad status");
	a_idle_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		bk_idle |-> !done) else $error("done while idle");
endmodule
`default_nettype wire
